@@ hdl/pru_pkg.sv @@
`timescale 1ns / 1ps

package pru_pkg;

  // result kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_PAD   = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  // input modes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IN_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IN_HEIGHT = 2'd2;

  localparam int SCALE_W  = 7;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;

  typedef logic [23:0] pru_pix_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pru_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic       image_end;
  } pru_out_t;

  // result descriptor handed from the sequencer to the output stage
  typedef struct packed {
    logic [1:0] kind;
    logic       use_mem;
    logic       row_end;
    logic       image_end;
  } pru_tag_t;

endpackage

@@ hdl/pru_line_buf.sv @@
`timescale 1ns / 1ps

module pru_line_buf #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  pru_pkg::pru_pix_t    wdata,
  input  logic                 ren,
  input  logic [ADDR_W-1:0]    raddr,
  output pru_pkg::pru_pix_t    rdata
);
  import pru_pkg::*;

  pru_pix_t mem [DEPTH];
  pru_pix_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/pru_ctrl.sv @@
`timescale 1ns / 1ps

module pru_ctrl #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 100,
  parameter int ADDR_W    = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pru_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pru_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             accept,
  input  pru_pkg::pru_in_t                 in_data,
  output logic                             tag_valid,
  output pru_pkg::pru_tag_t                tag,
  output logic                             mem_we,
  output logic [ADDR_W-1:0]                mem_waddr,
  output pru_pkg::pru_pix_t                mem_wdata,
  output logic                             mem_ren,
  output logic [ADDR_W-1:0]                mem_raddr
);
  import pru_pkg::*;

  localparam int WIDX_W = $clog2(MAX_WIDTH + 1);
  localparam int SC_W   = $clog2(MAX_SCALE + 1);

  logic [SCALE_W-1:0]  cfg_scale_r;
  logic [WIDTH_W-1:0]  cfg_width_r;
  logic [HEIGHT_W-1:0] cfg_height_r;

  logic [WIDX_W-1:0]   write_index_r, write_index_nxt;
  logic                replay_r, replay_nxt;
  logic [WIDX_W-1:0]   source_index_r, source_index_nxt;
  logic [SC_W-1:0]     pixel_repeat_r, pixel_repeat_nxt;
  logic [SC_W-1:0]     row_repeat_r, row_repeat_nxt;
  logic [1:0]          pad_left_r, pad_left_nxt;
  logic [HEIGHT_W-1:0] rows_done_r, rows_done_nxt;

  logic [WIDX_W-1:0]   w_eff;
  logic [SC_W-1:0]     n_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [WIDX_W:0]     write_inc;
  logic [WIDX_W:0]     source_inc;
  logic [SC_W:0]       pixel_inc;
  logic [SC_W:0]       row_inc;
  logic [HEIGHT_W:0]   rows_inc;
  logic [1:0]          pad_mul;
  logic                finish;
  logic                img_end;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_scale_r  <= SCALE_W'(1);
      cfg_width_r  <= WIDTH_W'(1);
      cfg_height_r <= HEIGHT_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SCALE:     cfg_scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_IN_WIDTH:  cfg_width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_IN_HEIGHT: cfg_height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings
  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = WIDX_W'(1);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = WIDX_W'(MAX_WIDTH);
    end else begin
      w_eff = WIDX_W'(cfg_width_r);
    end
    if (cfg_scale_r == '0) begin
      n_eff = SC_W'(1);
    end else if (32'(cfg_scale_r) > MAX_SCALE) begin
      n_eff = SC_W'(MAX_SCALE);
    end else begin
      n_eff = SC_W'(cfg_scale_r);
    end
    h_eff = (cfg_height_r == '0) ? HEIGHT_W'(1) : cfg_height_r;
  end

  assign write_inc  = {1'b0, write_index_r} + 1'b1;
  assign source_inc = {1'b0, source_index_r} + 1'b1;
  assign pixel_inc  = {1'b0, pixel_repeat_r} + 1'b1;
  assign row_inc    = {1'b0, row_repeat_r} + 1'b1;
  assign rows_inc   = {1'b0, rows_done_r} + 1'b1;
  // (w*n) mod 4 only needs the low two bits of each factor
  assign pad_mul    = 2'(w_eff) * 2'(n_eff);

  always_comb begin
    write_index_nxt  = write_index_r;
    replay_nxt       = replay_r;
    source_index_nxt = source_index_r;
    pixel_repeat_nxt = pixel_repeat_r;
    row_repeat_nxt   = row_repeat_r;
    pad_left_nxt     = pad_left_r;
    rows_done_nxt    = rows_done_r;
    tag_valid        = 1'b0;
    tag              = '0;
    mem_we           = 1'b0;
    mem_waddr        = ADDR_W'(write_index_r);
    mem_wdata        = {in_data.red, in_data.green, in_data.blue};
    mem_ren          = 1'b0;
    mem_raddr        = ADDR_W'(source_index_r);
    finish           = 1'b0;
    img_end          = 1'b0;

    if (accept) begin
      if (in_data.mode == MODE_PUSH) begin
        if (replay_r) begin
          tag_valid = 1'b1;
          tag.kind  = KIND_DROP;
        end else begin
          mem_we          = (32'(write_index_r) < MAX_WIDTH);
          write_index_nxt = WIDX_W'(write_inc);
          if (write_inc >= {1'b0, w_eff}) begin
            replay_nxt       = 1'b1;
            source_index_nxt = '0;
            pixel_repeat_nxt = '0;
            row_repeat_nxt   = '0;
            pad_left_nxt     = '0;
          end
        end
      end else if (replay_r) begin
        tag_valid = 1'b1;
        if (pad_left_r != 2'd0) begin
          tag.kind     = KIND_PAD;
          pad_left_nxt = pad_left_r - 2'd1;
          if (pad_left_r == 2'd1) begin
            tag.row_end = 1'b1;
            finish      = 1'b1;
          end
        end else begin
          tag.kind    = KIND_PIXEL;
          tag.use_mem = (32'(source_index_r) < MAX_WIDTH);
          mem_ren     = tag.use_mem;
          pixel_repeat_nxt = SC_W'(pixel_inc);
          if (pixel_inc >= {1'b0, n_eff}) begin
            pixel_repeat_nxt = '0;
            source_index_nxt = WIDX_W'(source_inc);
            if (source_inc >= {1'b0, w_eff}) begin
              if (pad_mul != 2'd0) begin
                pad_left_nxt = pad_mul;
              end else begin
                tag.row_end = 1'b1;
                finish      = 1'b1;
              end
            end
          end
        end
      end
    end

    // close an output row
    if (finish) begin
      row_repeat_nxt   = SC_W'(row_inc);
      source_index_nxt = '0;
      pixel_repeat_nxt = '0;
      pad_left_nxt     = '0;
      if (row_inc >= {1'b0, n_eff}) begin
        row_repeat_nxt  = '0;
        replay_nxt      = 1'b0;
        write_index_nxt = '0;
        if (rows_inc >= {1'b0, h_eff}) begin
          img_end       = 1'b1;
          rows_done_nxt = '0;
        end else begin
          rows_done_nxt = HEIGHT_W'(rows_inc);
        end
      end
    end
    tag.image_end = img_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_index_r  <= '0;
      replay_r       <= 1'b0;
      source_index_r <= '0;
      pixel_repeat_r <= '0;
      row_repeat_r   <= '0;
      pad_left_r     <= '0;
      rows_done_r    <= '0;
    end else begin
      write_index_r  <= write_index_nxt;
      replay_r       <= replay_nxt;
      source_index_r <= source_index_nxt;
      pixel_repeat_r <= pixel_repeat_nxt;
      row_repeat_r   <= row_repeat_nxt;
      pad_left_r     <= pad_left_nxt;
      rows_done_r    <= rows_done_nxt;
    end
  end

endmodule

@@ hdl/pru_out.sv @@
`timescale 1ns / 1ps

module pru_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tag_valid,
  input  pru_pkg::pru_tag_t   tag,
  input  pru_pkg::pru_pix_t   rdata,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output pru_pkg::pru_out_t   out_data
);
  import pru_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  pru_tag_t s1_tag_r;
  logic     out_valid_r, out_valid_nxt;
  pru_out_t out_data_r, out_data_nxt;
  logic     adv;

  // stage 1 moves on when the output register is empty or being drained
  assign adv  = s1_valid_r && (!out_valid_r || !out_stall);
  assign busy = s1_valid_r && !adv;

  always_comb begin
    s1_valid_nxt  = tag_valid || (s1_valid_r && !adv);
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (adv) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.kind      = s1_tag_r.kind;
      out_data_nxt.row_end   = s1_tag_r.row_end;
      out_data_nxt.image_end = s1_tag_r.image_end;
      out_data_nxt.out_blue  = s1_tag_r.use_mem ? rdata[7:0]   : 8'd0;
      out_data_nxt.out_green = s1_tag_r.use_mem ? rdata[15:8]  : 8'd0;
      out_data_nxt.out_red   = s1_tag_r.use_mem ? rdata[23:16] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_valid) begin
      s1_tag_r <= tag;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/pixel_replicate_upscaler.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  pru_in_t  (mode, blue, green, red)
// out_      output     out_valid / out_stall pru_out_t (kind, bytes, row_end, image_end)
// cfg_      input      cfg_we               cfg_addr, cfg_wdata (scale, in_width, in_height)
//
// one item is taken every cycle unless in_stall is high; a pull that yields a result passes
// through the registered read of the line memory and then the output register
// a push outside a replay writes the line memory and gives no result
// rst_n is synchronous; the line memory is not cleared and holds garbage until written
// in_stall rises only while stage 1 holds a result and the output register is stalled

module pixel_replicate_upscaler #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 100
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pru_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pru_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pru_pkg::pru_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pru_pkg::pru_out_t               out_data
);
  import pru_pkg::*;

  // line memory address width, at least one bit
  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic              accept;
  logic              tag_valid;
  pru_tag_t          tag;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  pru_pix_t          mem_wdata;
  logic              mem_ren;
  logic [ADDR_W-1:0] mem_raddr;
  pru_pix_t          mem_rdata;
  logic              busy;

  // an item enters whenever stage 1 is free or about to move on
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  // sequencer: push/replay counters, result tags and memory requests
  pru_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_data   (in_data),
    .tag_valid (tag_valid),
    .tag       (tag),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_ren   (mem_ren),
    .mem_raddr (mem_raddr)
  );

  // one row of input pixels, read data registered
  pru_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .ren   (mem_ren),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // stage 1 tag plus output register; memory data only changes on a new read
  pru_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_valid (tag_valid),
    .tag       (tag),
    .rdata     (mem_rdata),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/pru_checker.sv @@
`timescale 1ns / 1ps

module pru_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input pru_pkg::pru_out_t  out_data
);
  import pru_pkg::*;

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a dropped push carries no bytes and no row or image flags
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_DROP |->
      out_data.out_blue == 8'd0 && out_data.out_green == 8'd0 &&
      out_data.out_red == 8'd0 && !out_data.row_end && !out_data.image_end)
    else $error("drop result not clean");

  // pad bytes are zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_PAD |->
      out_data.out_blue == 8'd0 && out_data.out_green == 8'd0 &&
      out_data.out_red == 8'd0)
    else $error("pad result not zero");

  // image end only on the last element of a row
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.image_end |-> out_data.row_end)
    else $error("image end without row end");

endmodule

bind pixel_replicate_upscaler pru_checker u_pru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
